/* rtl/aat_pkg.sv */
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants of the box transform
// Matrix entry layout and the stage enable bundle of the pipeline.
// ----------------------------------------------------------------------------
package aat_pkg;

    // one signed matrix entry, three packed per row, column 0 lowest
    localparam int ENTRY_BITS = 16;
    localparam int AXES       = 3;
    localparam int ROW_BITS   = AXES * ENTRY_BITS;

    // per stage advance enables, driven by the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

/* rtl/aat_if.sv */
// ----------------------------------------------------------------------------
// aat_if: channel interfaces of the box transform
// Valid/ready channels for the local box with its transform and for the
// resulting world bounds.
// ----------------------------------------------------------------------------
interface aat_box_if #(
    parameter int COORD_BITS = 32
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS-1:0]       local_min_x;
    logic signed [COORD_BITS-1:0]       local_min_y;
    logic signed [COORD_BITS-1:0]       local_min_z;
    logic signed [COORD_BITS-1:0]       local_max_x;
    logic signed [COORD_BITS-1:0]       local_max_y;
    logic signed [COORD_BITS-1:0]       local_max_z;
    logic [aat_pkg::ROW_BITS-1:0]       linear_row0;
    logic [aat_pkg::ROW_BITS-1:0]       linear_row1;
    logic [aat_pkg::ROW_BITS-1:0]       linear_row2;
    logic signed [COORD_BITS-1:0]       shift_x;
    logic signed [COORD_BITS-1:0]       shift_y;
    logic signed [COORD_BITS-1:0]       shift_z;

    modport source (
        output valid, local_min_x, local_min_y, local_min_z,
               local_max_x, local_max_y, local_max_z,
               linear_row0, linear_row1, linear_row2,
               shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, local_min_x, local_min_y, local_min_z,
               local_max_x, local_max_y, local_max_z,
               linear_row0, linear_row1, linear_row2,
               shift_x, shift_y, shift_z,
        output ready
    );
endinterface

interface aat_bounds_if #(
    parameter int COORD_BITS = 32
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS-1:0]       world_min_x;
    logic signed [COORD_BITS-1:0]       world_min_y;
    logic signed [COORD_BITS-1:0]       world_min_z;
    logic signed [COORD_BITS-1:0]       world_max_x;
    logic signed [COORD_BITS-1:0]       world_max_y;
    logic signed [COORD_BITS-1:0]       world_max_z;

    modport source (
        output valid, world_min_x, world_min_y, world_min_z,
               world_max_x, world_max_y, world_max_z,
        input  ready
    );
    modport sink (
        input  valid, world_min_x, world_min_y, world_min_z,
               world_max_x, world_max_y, world_max_z,
        output ready
    );
endinterface

/* rtl/aabb_affine_transform.sv */
// ----------------------------------------------------------------------------
// aabb_affine_transform: world bounds of a local box under an affine map
// Maps all eight corners of a box and returns their per axis min and max.
// ----------------------------------------------------------------------------
// Usage:
//   i_box carries one transaction per box: the local min and max corners in
//   signed Q16.16, three packed rows of signed Q4.12 matrix entries and the
//   translation. o_bounds carries the world min and max corners, floored to
//   the coordinate format and saturated.
//   A box passes the product, extremes, sums and output registers to o_bounds.
//   Throughput is one box per cycle unless o_bounds stalls; the multiply stage
//   (eighteen 16 x 32 products) sets the cycle, with a register after it.
//   Every stage has its own valid bit and advances when it is empty or when
//   the next stage advances, so bubbles close up while the receiver stalls
//   and i_box.ready stays high until the pipeline is full. A stall drops and
//   repeats nothing; the held result stays stable on o_bounds.
//   Reset clears the valid bits only; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module aabb_affine_transform #(
    parameter int COORD_BITS       = 32,
    parameter int LINEAR_FRAC_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aat_box_if.sink       i_box,
    aat_bounds_if.source  o_bounds
);
    aat_pkg::t_stage_en en;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic signed [COORD_BITS-1:0] lo    [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] hi    [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] sh    [aat_pkg::AXES];
    logic [aat_pkg::ROW_BITS-1:0] rows  [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] w_min [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] w_max [aat_pkg::AXES];

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        en.s4 = !r_v4 || o_bounds.ready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_box.valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    assign i_box.ready = en.s1;

    // gather the input transaction per axis
    always_comb begin
        lo[0]   = i_box.local_min_x;
        lo[1]   = i_box.local_min_y;
        lo[2]   = i_box.local_min_z;
        hi[0]   = i_box.local_max_x;
        hi[1]   = i_box.local_max_y;
        hi[2]   = i_box.local_max_z;
        rows[0] = i_box.linear_row0;
        rows[1] = i_box.linear_row1;
        rows[2] = i_box.linear_row2;
        sh[0]   = i_box.shift_x;
        sh[1]   = i_box.shift_y;
        sh[2]   = i_box.shift_z;
    end

    // one datapath per world axis
    for (genvar a = 0; a < aat_pkg::AXES; a++) begin : g_row
        aat_row #(
            .COORD_BITS       (COORD_BITS),
            .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS)
        ) u_row (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_lo    (lo),
            .i_hi    (hi),
            .i_row   (rows[a]),
            .i_shift (sh[a]),
            .o_min   (w_min[a]),
            .o_max   (w_max[a])
        );
    end

    // output transaction
    assign o_bounds.valid       = r_v4;
    assign o_bounds.world_min_x = w_min[0];
    assign o_bounds.world_min_y = w_min[1];
    assign o_bounds.world_min_z = w_min[2];
    assign o_bounds.world_max_x = w_max[0];
    assign o_bounds.world_max_y = w_max[1];
    assign o_bounds.world_max_z = w_max[2];

endmodule

/* rtl/aat_row.sv */
// ----------------------------------------------------------------------------
// aat_row: one output axis of the box transform
// Four stage datapath: products, per column min/max, column sums, then floor,
// translation and saturation. Floor and saturation are monotonic, so the
// bound over the eight corners equals the mapped sum of per column extremes.
// ----------------------------------------------------------------------------
module aat_row #(
    parameter int COORD_BITS       = 32,
    parameter int LINEAR_FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  aat_pkg::t_stage_en                  i_en,
    input  logic signed [COORD_BITS-1:0]        i_lo [aat_pkg::AXES],
    input  logic signed [COORD_BITS-1:0]        i_hi [aat_pkg::AXES],
    input  logic [aat_pkg::ROW_BITS-1:0]        i_row,
    input  logic signed [COORD_BITS-1:0]        i_shift,
    output logic signed [COORD_BITS-1:0]        o_min,
    output logic signed [COORD_BITS-1:0]        o_max
);
    localparam int PW = aat_pkg::ENTRY_BITS + COORD_BITS;  // exact product
    localparam int SW = PW + 2;                            // sum of three
    localparam int FW = SW - LINEAR_FRAC_BITS;             // floored sum
    localparam int WW = FW + 1;                            // plus translation

    localparam logic signed [WW-1:0] SAT_HI = {{(WW-COORD_BITS+1){1'b0}},
                                               {(COORD_BITS-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_LO = {{(WW-COORD_BITS+1){1'b1}},
                                               {(COORD_BITS-1){1'b0}}};

    logic signed [aat_pkg::ENTRY_BITS-1:0] entry [aat_pkg::AXES];

    logic signed [PW-1:0]         r_plo [aat_pkg::AXES];
    logic signed [PW-1:0]         r_phi [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] r_sh1;
    logic signed [PW-1:0]         r_mn [aat_pkg::AXES];
    logic signed [PW-1:0]         r_mx [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] r_sh2;
    logic signed [SW-1:0]         r_smn;
    logic signed [SW-1:0]         r_smx;
    logic signed [COORD_BITS-1:0] r_sh3;
    logic signed [COORD_BITS-1:0] r_min;
    logic signed [COORD_BITS-1:0] r_max;

    logic signed [FW-1:0] fl_mn;
    logic signed [FW-1:0] fl_mx;
    logic signed [WW-1:0] n_wmn;
    logic signed [WW-1:0] n_wmx;
    logic signed [COORD_BITS-1:0] n_min;
    logic signed [COORD_BITS-1:0] n_max;

    // unpack the signed matrix entries of this row
    always_comb begin
        for (int c = 0; c < aat_pkg::AXES; c++) begin
            entry[c] = i_row[c*aat_pkg::ENTRY_BITS +: aat_pkg::ENTRY_BITS];
        end
    end

    // stage 1: exact products with both corner coordinates
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int c = 0; c < aat_pkg::AXES; c++) begin
                r_plo[c] <= PW'(entry[c]) * PW'(i_lo[c]);
                r_phi[c] <= PW'(entry[c]) * PW'(i_hi[c]);
            end
            r_sh1 <= i_shift;
        end
    end

    // stage 2: per column extremes
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int c = 0; c < aat_pkg::AXES; c++) begin
                r_mn[c] <= (r_plo[c] < r_phi[c]) ? r_plo[c] : r_phi[c];
                r_mx[c] <= (r_plo[c] < r_phi[c]) ? r_phi[c] : r_plo[c];
            end
            r_sh2 <= r_sh1;
        end
    end

    // stage 3: column sums
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_smn <= SW'(r_mn[0]) + SW'(r_mn[1]) + SW'(r_mn[2]);
            r_smx <= SW'(r_mx[0]) + SW'(r_mx[1]) + SW'(r_mx[2]);
            r_sh3 <= r_sh2;
        end
    end

    // stage 4: floor to coordinate format, translate, saturate
    always_comb begin
        fl_mn = r_smn[SW-1:LINEAR_FRAC_BITS];
        fl_mx = r_smx[SW-1:LINEAR_FRAC_BITS];
        n_wmn = WW'(fl_mn) + WW'(r_sh3);
        n_wmx = WW'(fl_mx) + WW'(r_sh3);
        if (n_wmn > SAT_HI) begin
            n_min = SAT_HI[COORD_BITS-1:0];
        end else if (n_wmn < SAT_LO) begin
            n_min = SAT_LO[COORD_BITS-1:0];
        end else begin
            n_min = n_wmn[COORD_BITS-1:0];
        end
        if (n_wmx > SAT_HI) begin
            n_max = SAT_HI[COORD_BITS-1:0];
        end else if (n_wmx < SAT_LO) begin
            n_max = SAT_LO[COORD_BITS-1:0];
        end else begin
            n_max = n_wmx[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

/* dv/aabb_affine_transform_tb.sv */
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb: self-checking bench for the box transform
// Drives local boxes with random and corner-case affine maps, predicts the
// world bounds of all eight mapped corners in exact wide arithmetic, and
// compares each bounds transaction in order, under random idling on both
// channels and long receiver stalls that back the pipeline up.
// ----------------------------------------------------------------------------
module aabb_affine_transform_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CB          = 32;
    localparam int    FRAC        = 12;
    localparam int    EB          = aat_pkg::ENTRY_BITS;
    localparam int    N_RANDOM    = 935;
    localparam int    MAX_IDLE    = 17;
    localparam int    HOLD_CYCLES = 120;
    localparam int    DRAIN_WAIT  = 16;
    localparam int    CYCLE_LIMIT = 200000;
    localparam longint SAT_HI     = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint SAT_LO     = -SAT_HI - 1;

    typedef logic signed [CB-1:0]          t_coord;
    typedef logic [aat_pkg::ROW_BITS-1:0]  t_row;

    typedef struct {
        t_coord lo[3];
        t_coord hi[3];
        t_row   row[3];
        t_coord sh[3];
    } t_box;

    typedef struct {
        t_coord lo[3];
        t_coord hi[3];
    } t_bounds;

    // common coordinate and matrix values
    localparam t_coord C_MAX  = 32'sh7FFF_FFFF;
    localparam t_coord C_MIN  = 32'sh8000_0000;
    localparam t_coord C_ONE  = 32'sh0001_0000;
    localparam logic [EB-1:0] E_ONE  = 16'h1000;
    localparam logic [EB-1:0] E_NEG  = 16'hF000;
    localparam t_row   ID_ROW0 = {16'h0000, 16'h0000, E_ONE};
    localparam t_row   ID_ROW1 = {16'h0000, E_ONE, 16'h0000};
    localparam t_row   ID_ROW2 = {E_ONE, 16'h0000, 16'h0000};

    // ------------------------------------------------------------------------
    // world bounds predictor and in-order store of expected bounds
    // ------------------------------------------------------------------------
    class bounds_scoreboard;
        t_bounds pending[$];
        int      errors;
        int      n_checked;

        function new();
            errors    = 0;
            n_checked = 0;
        endfunction

        // one row of the map on one point: exact sum, floored, saturated
        function t_coord map_axis(t_row row, t_coord pt[3], t_coord sh);
            logic signed [63:0]   acc;
            logic signed [63:0]   prod;
            logic signed [EB-1:0] ent;
            acc = sh;
            acc = acc <<< FRAC;
            for (int c = 0; c < 3; c++) begin
                ent  = row[c*EB +: EB];
                prod = ent * pt[c];
                acc  = acc + prod;
            end
            acc = acc >>> FRAC;
            if (acc > SAT_HI) return SAT_HI[CB-1:0];
            if (acc < SAT_LO) return SAT_LO[CB-1:0];
            return acc[CB-1:0];
        endfunction

        function t_bounds box_bounds(t_box b);
            t_bounds r;
            t_coord  pt[3];
            t_coord  w;
            for (int k = 0; k < 8; k++) begin
                pt[0] = (k & 1) ? b.hi[0] : b.lo[0];
                pt[1] = (k & 2) ? b.hi[1] : b.lo[1];
                pt[2] = (k & 4) ? b.hi[2] : b.lo[2];
                for (int a = 0; a < 3; a++) begin
                    w = map_axis(b.row[a], pt, b.sh[a]);
                    if (k == 0 || w < r.lo[a]) r.lo[a] = w;
                    if (k == 0 || w > r.hi[a]) r.hi[a] = w;
                end
            end
            return r;
        endfunction

        function void note_box(t_box b);
            pending.push_back(box_bounds(b));
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("ERROR: bounds transaction %0d: %s", n_checked, what);
        endtask

        task check_bounds(t_bounds got);
            t_bounds exp;
            string   axis;
            if (pending.size() == 0) begin
                report_mismatch("world bounds with no box outstanding");
                return;
            end
            exp  = pending.pop_front();
            axis = "xyz";
            for (int a = 0; a < 3; a++) begin
                if (got.lo[a] !== exp.lo[a])
                    report_mismatch($sformatf("world_min_%c got %0d expected %0d",
                                              axis[a], got.lo[a], exp.lo[a]));
                if (got.hi[a] !== exp.hi[a])
                    report_mismatch($sformatf("world_max_%c got %0d expected %0d",
                                              axis[a], got.hi[a], exp.hi[a]));
            end
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    aat_box_if    #(.COORD_BITS(CB)) box_ch ();
    aat_bounds_if #(.COORD_BITS(CB)) bounds_ch ();

    aabb_affine_transform #(
        .COORD_BITS       (CB),
        .LINEAR_FRAC_BITS (FRAC)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_box    (box_ch),
        .o_bounds (bounds_ch)
    );

    bounds_scoreboard sb = new();

    int      tx_gap_max;
    int      rx_stall_max;
    int      hold_req;
    int      cycle_count = 0;
    t_box    seen_box;
    t_bounds seen_bounds;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aabb_affine_transform: mismatch");
            $finish;
        end
    end

    // monitors: inputs only move at the rising edge, so the falling edge
    // sees the handshake that fires at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (box_ch.valid && box_ch.ready) begin
                seen_box.lo  = '{box_ch.local_min_x, box_ch.local_min_y, box_ch.local_min_z};
                seen_box.hi  = '{box_ch.local_max_x, box_ch.local_max_y, box_ch.local_max_z};
                seen_box.row = '{box_ch.linear_row0, box_ch.linear_row1, box_ch.linear_row2};
                seen_box.sh  = '{box_ch.shift_x, box_ch.shift_y, box_ch.shift_z};
                sb.note_box(seen_box);
            end
            if (bounds_ch.valid && bounds_ch.ready) begin
                seen_bounds.lo = '{bounds_ch.world_min_x, bounds_ch.world_min_y,
                                   bounds_ch.world_min_z};
                seen_bounds.hi = '{bounds_ch.world_max_x, bounds_ch.world_max_y,
                                   bounds_ch.world_max_z};
                sb.check_bounds(seen_bounds);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_box uniform_box(t_coord lo, t_coord hi, t_row row, t_coord sh);
        t_box b;
        for (int a = 0; a < 3; a++) begin
            b.lo[a]  = lo;
            b.hi[a]  = hi;
            b.row[a] = row;
            b.sh[a]  = sh;
        end
        return b;
    endfunction

    function automatic t_coord rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [EB-1:0] rand_entry();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1, 2, 3: return EB'($urandom);
            default: return EB'(int'($urandom_range(0, 16'h2000)) - 32'sh0000_1000);
        endcase
    endfunction

    function automatic t_row rand_row();
        return {rand_entry(), rand_entry(), rand_entry()};
    endfunction

    // offer one box after a random gap; returns at the edge it was taken
    task automatic send_box(t_box b, int gap);
        bit fired;
        if (gap > 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_ch.valid       <= 1'b1;
        box_ch.local_min_x <= b.lo[0];
        box_ch.local_min_y <= b.lo[1];
        box_ch.local_min_z <= b.lo[2];
        box_ch.local_max_x <= b.hi[0];
        box_ch.local_max_y <= b.hi[1];
        box_ch.local_max_z <= b.hi[2];
        box_ch.linear_row0 <= b.row[0];
        box_ch.linear_row1 <= b.row[1];
        box_ch.linear_row2 <= b.row[2];
        box_ch.shift_x     <= b.sh[0];
        box_ch.shift_y     <= b.sh[1];
        box_ch.shift_z     <= b.sh[2];
        do begin
            @(negedge i_clk);
            fired = box_ch.ready;
            @(posedge i_clk);
        end while (!fired);
    endtask

    function automatic int draw_idle(int limit);
        return (limit > 0) ? $urandom_range(0, limit) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls per transaction, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        bit fired;
        int holds_done;
        holds_done = 0;
        bounds_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_req) begin
                holds_done = hold_req;
                bounds_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = draw_idle(rx_stall_max);
            if (stall > 0) begin
                bounds_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            bounds_ch.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                fired = bounds_ch.valid;
                @(posedge i_clk);
            end while (!fired);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_box   b;
        int     burst;
        int     gap;
        t_coord t;

        i_rst_n      <= 1'b0;
        box_ch.valid <= 1'b0;
        box_ch.local_min_x <= '0;
        box_ch.local_min_y <= '0;
        box_ch.local_min_z <= '0;
        box_ch.local_max_x <= '0;
        box_ch.local_max_y <= '0;
        box_ch.local_max_z <= '0;
        box_ch.linear_row0 <= '0;
        box_ch.linear_row1 <= '0;
        box_ch.linear_row2 <= '0;
        box_ch.shift_x     <= '0;
        box_ch.shift_y     <= '0;
        box_ch.shift_z     <= '0;
        tx_gap_max   = MAX_IDLE;
        rx_stall_max = MAX_IDLE;
        hold_req     = 0;
        burst        = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all zero
        send_box(uniform_box('0, '0, '0, '0), draw_idle(tx_gap_max));
        // identity map of a unit box with a mixed translation
        b = uniform_box(-C_ONE, C_ONE, '0, '0);
        b.row = '{ID_ROW0, ID_ROW1, ID_ROW2};
        b.sh  = '{32'sh0001_8000, 32'shFFFD_C000, '0};
        send_box(b, draw_idle(tx_gap_max));
        // min above max, left as given, under a rotation about z
        b = uniform_box(3 * C_ONE, -2 * C_ONE, '0, C_ONE);
        b.row = '{{16'h0000, E_NEG, 16'h0000}, ID_ROW0, ID_ROW2};
        send_box(b, draw_idle(tx_gap_max));
        // positive overflow from largest coordinates and entries
        send_box(uniform_box(C_MAX, C_MAX, {3{16'h7FFF}}, '0), draw_idle(tx_gap_max));
        // both saturations at once
        send_box(uniform_box(C_MIN, C_MAX, {3{16'h8000}}, C_MIN), draw_idle(tx_gap_max));
        // most negative times most negative, plus largest shift
        send_box(uniform_box(C_MIN, C_MIN, {3{16'h8000}}, C_MAX), draw_idle(tx_gap_max));
        // fraction flooring: tiny products of both signs
        send_box(uniform_box(-1, 1, {3{16'h0001}}, '0), draw_idle(tx_gap_max));
        send_box(uniform_box(1, 1, {3{16'hFFFF}}, '0), draw_idle(tx_gap_max));
        send_box(uniform_box(-1, -1, {3{16'h0001}}, '0), draw_idle(tx_gap_max));
        // translation extremes on top of identity
        b = uniform_box(C_ONE, C_ONE, '0, C_MAX);
        b.row = '{ID_ROW0, ID_ROW1, ID_ROW2};
        send_box(b, draw_idle(tx_gap_max));
        b = uniform_box(-C_ONE, -C_ONE, '0, C_MIN);
        b.row = '{ID_ROW0, ID_ROW1, ID_ROW2};
        send_box(b, draw_idle(tx_gap_max));
        // rotation about z on an uneven box
        b = uniform_box('0, '0, '0, '0);
        b.lo  = '{-C_ONE, -2 * C_ONE, -3 * C_ONE};
        b.hi  = '{4 * C_ONE, 5 * C_ONE, 6 * C_ONE};
        b.row = '{{16'h0000, E_NEG, 16'h0000}, ID_ROW0, ID_ROW2};
        send_box(b, draw_idle(tx_gap_max));
        // all ones everywhere
        send_box(uniform_box('1, '1, '1, '1), draw_idle(tx_gap_max));
        // alternating bit patterns
        send_box(uniform_box(32'sh5555_5555, 32'shAAAA_AAAA, {3{16'h5A5A}}, 32'sh1234_5678),
                 draw_idle(tx_gap_max));
        send_box(uniform_box(32'shAAAA_AAAA, 32'sh5555_5555, {3{16'hA5A5}}, 32'shEDCB_A987),
                 draw_idle(tx_gap_max));
        // full-scale entries on fractional coordinates
        send_box(uniform_box(32'shFFFE_8000, 32'sh0001_8000, {16'h8000, 16'h7FFF, 16'h8001},
                             32'sh0000_0001), draw_idle(tx_gap_max));
        // zero matrix: bounds are the translation alone
        send_box(uniform_box(C_MIN, C_MAX, '0, 32'shFFFF_0000), draw_idle(tx_gap_max));

        // random boxes, idling mode changes every 64 transactions
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0) begin
                gap          = $urandom_range(0, 3);
                tx_gap_max   = gap[0] ? MAX_IDLE : 0;
                rx_stall_max = gap[1] ? MAX_IDLE : 0;
            end
            // long receiver hold-off while boxes keep coming back to back
            if (i == 300 || i == 700) begin
                hold_req = hold_req + 1;
                burst    = 40;
            end
            for (int a = 0; a < 3; a++) begin
                b.lo[a]  = rand_coord();
                b.hi[a]  = rand_coord();
                b.row[a] = rand_row();
                b.sh[a]  = rand_coord();
                // mostly well-formed boxes, some with min above max
                if ($urandom_range(0, 9) < 8 && b.lo[a] > b.hi[a]) begin
                    t       = b.lo[a];
                    b.lo[a] = b.hi[a];
                    b.hi[a] = t;
                end
            end
            if (burst > 0) begin
                burst--;
                send_box(b, 0);
            end else begin
                send_box(b, draw_idle(tx_gap_max));
            end
        end
        box_ch.valid <= 1'b0;

        // drain
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0)
            $display("aabb_affine_transform: match");
        else
            $display("aabb_affine_transform: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/aat_pkg.sv
rtl/aat_if.sv
rtl/aat_row.sv
rtl/aabb_affine_transform.sv
dv/aabb_affine_transform_tb.sv
